// ----- rtl/core/rdp_pkg.sv -----
// Package for the rotary dial pulse decoder.
// Holds the phase encoding, register indexes, reset values and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package rdp_pkg;

  localparam int unsigned CfgW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned TallyW = 4;
  localparam int unsigned DigitW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TallyW-1:0] TallyMax = TallyW'(10);

  localparam logic [CfgW-1:0] MinBreakRst = CfgW'(20);
  localparam logic [CfgW-1:0] MaxBreakRst = CfgW'(100);
  localparam logic [CfgW-1:0] IdTimeoutRst = CfgW'(300);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_BREAK  = 2'd0,
    CFG_MAX_BREAK  = 2'd1,
    CFG_ID_TIMEOUT = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BREAK = 2'd1,
    PH_MAKE  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0] min_break_ms;
    logic [CfgW-1:0] max_break_ms;
    logic [CfgW-1:0] id_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              pulse_seen;
    logic              digit_ready;
    logic [DigitW-1:0] digit;
  } res_t;

endpackage

// ----- rtl/core/rdp_if.sv -----
// Valid/ready channel interfaces for the rotary dial pulse decoder.
// Depends on rdp_pkg for field widths.
`timescale 1ns / 1ps

interface rdp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        line_break;
  logic [rdp_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, line_break, now_ms, input ready);
  modport sink   (input valid, line_break, now_ms, output ready);
endinterface

interface rdp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        pulse_seen;
  logic                        digit_ready;
  logic [rdp_pkg::DigitW-1:0]  digit;

  modport source (output valid, pulse_seen, digit_ready, digit, input ready);
  modport sink   (input valid, pulse_seen, digit_ready, digit, output ready);
endinterface

// ----- rtl/core/rotary_dial_pulse_decoder.sv -----
// Rotary dial pulse decoder: times loop breaks and makes, counts pulses, emits digits.
// Throughput one beat per cycle while the sink keeps out_if.ready high.
// Path: input register -> state update in rdp_core -> result register.
// Reset (rst_ni low, asynchronous) empties both registers, returns to idle, clears
// the tally, stamp and digit, and loads the default break window and timeout.
// Depends on rdp_pkg, rdp_if, rdp_cfg and rdp_core.
`timescale 1ns / 1ps

module rotary_dial_pulse_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rdp_in_if.sink                        in_if,
  rdp_out_if.source                     out_if,
  input  logic                          cfg_we_i,
  input  logic [rdp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rdp_pkg::CfgW-1:0]      cfg_wdata_i
);

  // Input register: captures one sample beat.
  logic                          in_vld_q;
  logic                          in_brk_q;
  logic [rdp_pkg::TimeW-1:0]     in_now_q;

  // Result register: one result beat waiting for the sink.
  logic                          out_vld_q;
  rdp_pkg::res_t                 out_res_q;

  rdp_pkg::cfg_t                 cfg;
  rdp_pkg::res_t                 res;

  logic advance;   // move the held sample through the state machine
  logic in_take;

  // Advance a held sample whenever the result slot is free or being drained this cycle.
  assign advance  = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;
  assign in_take  = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  // Payload needs no reset; load it with each accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_brk_q <= in_if.line_break;
      in_now_q <= in_if.now_ms;
    end
  end

  rdp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // State update happens exactly once per sample, when it leaves the input register.
  rdp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (advance),
    .line_break_i (in_brk_q),
    .now_ms_i     (in_now_q),
    .res_o        (res)
  );

  // Hold the result until taken; refill on advance, drop valid when drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.pulse_seen  = out_res_q.pulse_seen;
  assign out_if.digit_ready = out_res_q.digit_ready;
  assign out_if.digit       = out_res_q.digit;

endmodule

// ----- rtl/core/rdp_cfg.sv -----
// Configuration register file of the rotary dial pulse decoder.
// Depends on rdp_pkg.
`timescale 1ns / 1ps

module rdp_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rdp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rdp_pkg::CfgW-1:0]      cfg_wdata_i,
  output rdp_pkg::cfg_t                 cfg_o
);

  rdp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rdp_pkg::CFG_MIN_BREAK:  cfg_d.min_break_ms  = cfg_wdata_i;
        rdp_pkg::CFG_MAX_BREAK:  cfg_d.max_break_ms  = cfg_wdata_i;
        rdp_pkg::CFG_ID_TIMEOUT: cfg_d.id_timeout_ms = cfg_wdata_i;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_break_ms  <= rdp_pkg::MinBreakRst;
      cfg_q.max_break_ms  <= rdp_pkg::MaxBreakRst;
      cfg_q.id_timeout_ms <= rdp_pkg::IdTimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/rdp_core.sv -----
// Break/make timing state machine of the rotary dial pulse decoder.
// Holds the decoder state and forms one result per sample. Depends on rdp_pkg.
`timescale 1ns / 1ps

module rdp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rdp_pkg::cfg_t                 cfg_i,
  input  logic                          step_i,
  input  logic                          line_break_i,
  input  logic [rdp_pkg::TimeW-1:0]     now_ms_i,
  output rdp_pkg::res_t                 res_o
);

  rdp_pkg::phase_e                   phase_q, phase_d;
  logic [rdp_pkg::TimeW-1:0]         stamp_q, stamp_d;
  logic [rdp_pkg::TallyW-1:0]        tally_q, tally_d;
  logic                              last_brk_q;
  logic [rdp_pkg::DigitW-1:0]        digit_q, digit_d;

  logic [rdp_pkg::TimeW-1:0] elapsed;
  logic                      opened;
  logic                      in_window;
  logic                      brk_over;
  logic                      make_over;
  logic                      pulse;
  logic                      ready;
  logic                      finish;

  assign elapsed   = now_ms_i - stamp_q;  // wraps modulo 2^32
  assign opened    = line_break_i && !last_brk_q;
  assign in_window = (elapsed >= rdp_pkg::TimeW'(cfg_i.min_break_ms)) &&
                     (elapsed <= rdp_pkg::TimeW'(cfg_i.max_break_ms));
  assign brk_over  = elapsed > rdp_pkg::TimeW'(cfg_i.max_break_ms);
  assign make_over = elapsed > rdp_pkg::TimeW'(cfg_i.id_timeout_ms);

  always_comb begin
    phase_d = phase_q;
    stamp_d = stamp_q;
    tally_d = tally_q;
    pulse   = 1'b0;
    finish  = 1'b0;
    unique case (phase_q)
      rdp_pkg::PH_IDLE: begin
        if (opened) begin
          stamp_d = now_ms_i;
          phase_d = rdp_pkg::PH_BREAK;
        end
      end
      rdp_pkg::PH_BREAK: begin
        if (!line_break_i) begin
          if (in_window) begin
            pulse = 1'b1;
            if (tally_q < rdp_pkg::TallyMax) begin
              tally_d = tally_q + 1'b1;
            end
          end
          stamp_d = now_ms_i;
          phase_d = rdp_pkg::PH_MAKE;
        end else if (brk_over) begin
          finish = 1'b1;
        end
      end
      rdp_pkg::PH_MAKE: begin
        if (opened) begin
          stamp_d = now_ms_i;
          phase_d = rdp_pkg::PH_BREAK;
        end else if (make_over) begin
          finish = 1'b1;
        end
      end
      default: phase_d = rdp_pkg::PH_IDLE;
    endcase

    // Close the digit: emit only if at least one pulse was counted.
    ready   = finish && (tally_q != '0);
    digit_d = digit_q;
    if (finish) begin
      phase_d = rdp_pkg::PH_IDLE;
      tally_d = '0;
    end
    if (ready) begin
      digit_d = (tally_q >= rdp_pkg::TallyMax) ? '0 : rdp_pkg::DigitW'(tally_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rdp_pkg::PH_IDLE;
      stamp_q    <= '0;
      tally_q    <= '0;
      last_brk_q <= 1'b0;
      digit_q    <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      stamp_q    <= stamp_d;
      tally_q    <= tally_d;
      last_brk_q <= line_break_i;
      digit_q    <= digit_d;
    end
  end

  assign res_o.pulse_seen  = pulse;
  assign res_o.digit_ready = ready;
  assign res_o.digit       = digit_d;

endmodule

// ----- rtl/core/rdp_checker.sv -----
// Port-level checks for the rotary dial pulse decoder, bound to the top level.
// Depends on rdp_pkg and rotary_dial_pulse_decoder.
`timescale 1ns / 1ps

module rdp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          pulse_seen_i,
  input logic                          digit_ready_i,
  input logic [rdp_pkg::DigitW-1:0]    digit_i
);

  // Digit carried by the last delivered beat.
  logic [rdp_pkg::DigitW-1:0] seen_digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_digit_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      seen_digit_q <= digit_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(digit_i)
      && $stable(pulse_seen_i) && $stable(digit_ready_i))
    else $error("result beat changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> digit_i <= rdp_pkg::DigitW'(9))
    else $error("digit out of range");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(pulse_seen_i && digit_ready_i))
    else $error("pulse and digit completion on one sample");

  a_digit_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !digit_ready_i |-> digit_i == seen_digit_q)
    else $error("digit changed without a completed digit");

endmodule

bind rotary_dial_pulse_decoder rdp_checker u_rdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .pulse_seen_i  (out_if.pulse_seen),
  .digit_ready_i (out_if.digit_ready),
  .digit_i       (out_if.digit)
);
